### rtl/ttl_pkg.sv
// Shared types, constants and helper functions for the TeX token lexer.
// No dependencies; imported by every module of the lexer.
package ttl_pkg;

    // Sizing of the control-word length counter
    localparam int TOKEN_BUFFER = 256;
    localparam int LEN_W        = $clog2(TOKEN_BUFFER);

    // Result queue depth (two slots per item plus slack)
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    // Token kinds
    localparam logic [2:0] KIND_CHAR  = 3'd0;
    localparam logic [2:0] KIND_CTRL  = 3'd1;
    localparam logic [2:0] KIND_BEGIN = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_ALIGN = 3'd4;
    localparam logic [2:0] KIND_EOT   = 3'd5;

    // Special bytes
    localparam logic [7:0] BYTE_NUL    = 8'h00;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_LBRACE = 8'h7B;
    localparam logic [7:0] BYTE_RBRACE = 8'h7D;
    localparam logic [7:0] BYTE_AMP    = 8'h26;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;

    // UTF-8 lead byte masks and patterns
    localparam logic [7:0] UTF2_MASK = 8'hE0;
    localparam logic [7:0] UTF2_PAT  = 8'hC0;
    localparam logic [7:0] UTF3_MASK = 8'hF0;
    localparam logic [7:0] UTF3_PAT  = 8'hE0;
    localparam logic [7:0] UTF4_MASK = 8'hF8;
    localparam logic [7:0] UTF4_PAT  = 8'hF0;

    // Lexer modes, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_BSLASH = 4'b0010,
        MODE_WORD   = 4'b0100,
        MODE_UTF8   = 4'b1000
    } lex_mode_t;

    // One result item
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tbyte;
        logic       present;
        logic       done;
        logic       last;
    } result_t;

    // Results caused by one input item
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } lex_out_t;

    // Outcome of lexing a byte from the idle mode
    typedef struct packed {
        logic       emit;
        result_t    res;
        lex_mode_t  mode;
        logic [1:0] cont;
        logic       bslash;
    } idle_t;

    function automatic result_t mk_res(logic [2:0] kind, logic [7:0] b,
                                       logic present, logic done);
        result_t r;
        r.kind    = kind;
        r.tbyte   = present ? b : BYTE_NUL;
        r.present = present;
        r.done    = done;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic logic is_letter(logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic idle_t idle_lex(logic [7:0] b);
        idle_t o;
        o.emit   = 1'b1;
        o.mode   = MODE_IDLE;
        o.cont   = 2'd0;
        o.bslash = 1'b0;
        o.res    = mk_res(KIND_CHAR, b, 1'b1, 1'b1);
        if (b == BYTE_NUL) begin
            o.res = mk_res(KIND_EOT, BYTE_NUL, 1'b0, 1'b1);
        end else if ((b == BYTE_SPACE) || (b == BYTE_TAB)) begin
            o.emit = 1'b0;
        end else if (b == BYTE_LBRACE) begin
            o.res = mk_res(KIND_BEGIN, b, 1'b1, 1'b1);
        end else if (b == BYTE_RBRACE) begin
            o.res = mk_res(KIND_END, b, 1'b1, 1'b1);
        end else if (b == BYTE_AMP) begin
            o.res = mk_res(KIND_ALIGN, b, 1'b1, 1'b1);
        end else if (b == BYTE_BSLASH) begin
            o.res    = mk_res(KIND_CTRL, b, 1'b1, 1'b0);
            o.mode   = MODE_BSLASH;
            o.bslash = 1'b1;
        end else if ((b & UTF2_MASK) == UTF2_PAT) begin
            o.res  = mk_res(KIND_CHAR, b, 1'b1, 1'b0);
            o.mode = MODE_UTF8;
            o.cont = 2'd1;
        end else if ((b & UTF3_MASK) == UTF3_PAT) begin
            o.res  = mk_res(KIND_CHAR, b, 1'b1, 1'b0);
            o.mode = MODE_UTF8;
            o.cont = 2'd2;
        end else if ((b & UTF4_MASK) == UTF4_PAT) begin
            o.res  = mk_res(KIND_CHAR, b, 1'b1, 1'b0);
            o.mode = MODE_UTF8;
            o.cont = 2'd3;
        end
        return o;
    endfunction

endpackage

### rtl/tex_token_lexer_unit.sv
// TeX token lexer: one text byte in, zero to two token results out.
// Results are written into the result queue when their byte is accepted and are offered from its head.
// Throughput: one byte per cycle; a four-entry result queue absorbs the
// second result of a byte, and input stalls only when fewer than two slots are free.
// Reset (aresetn low at a clock edge) returns the lexer to idle and empties the queue.
// Depends on ttl_pkg, ttl_core, ttl_queue.
module tex_token_lexer_unit
    import ttl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] token_byte, [8] last_result, zero fill
    output logic        m_tlast,   // token_done
    output logic [3:0]  m_tuser    // [2:0] token_kind, [3] byte_present
);

    logic     accept;
    lex_out_t lex_out;
    result_t  head;

    assign accept = s_tvalid && s_tready;

    // Classify the byte and update lexer state
    ttl_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (accept),
        .text_byte (s_tdata),
        .lex_out   (lex_out)
    );

    // Queue results toward the output
    ttl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .lex_in    (lex_out),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    // Pack the head result onto the output ports
    assign m_tdata = {7'd0, head.last, head.tbyte};
    assign m_tlast = head.done;
    assign m_tuser = {head.present, head.kind};

endmodule

### rtl/ttl_core.sv
// Lexer state machine: classifies each accepted byte and forms up to two results.
// Depends on ttl_pkg.
module ttl_core
    import ttl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic [7:0] text_byte,
    output lex_out_t   lex_out
);

    lex_mode_t        mode_reg, mode_next;
    logic [1:0]       cont_reg, cont_next;
    logic [LEN_W-1:0] len_reg, len_next;

    idle_t            idle;
    logic [1:0]       cont_dec;
    lex_out_t         o;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TOKEN_BUFFER - 1);

    // Form results and next state from the current mode and byte
    always_comb begin
        idle      = idle_lex(text_byte);
        cont_dec  = (cont_reg == 2'd0) ? 2'd0 : cont_reg - 2'd1;
        mode_next = mode_reg;
        cont_next = cont_reg;
        len_next  = len_reg;
        o.count   = 2'd0;
        o.r0      = '0;
        o.r1      = '0;
        case (mode_reg)
            MODE_BSLASH: begin
                o.count = 2'd1;
                len_next  = '0;
                mode_next = MODE_IDLE;
                if (text_byte == BYTE_NUL) begin
                    o.r0    = mk_res(KIND_CTRL, BYTE_NUL, 1'b0, 1'b1);
                    o.r1    = idle.res;
                    o.count = 2'd2;
                end else if (is_letter(text_byte)) begin
                    o.r0      = mk_res(KIND_CTRL, text_byte, 1'b1, 1'b0);
                    mode_next = MODE_WORD;
                    len_next  = LEN_W'(2);
                end else begin
                    o.r0 = mk_res(KIND_CTRL, text_byte, 1'b1, 1'b1);
                end
            end
            MODE_WORD: begin
                if (is_letter(text_byte)) begin
                    // drop letters past the buffer length
                    if (len_reg < LEN_MAX) begin
                        o.r0     = mk_res(KIND_CTRL, text_byte, 1'b1, 1'b0);
                        o.count  = 2'd1;
                        len_next = len_reg + LEN_W'(1);
                    end
                end else begin
                    o.r0      = mk_res(KIND_CTRL, BYTE_NUL, 1'b0, 1'b1);
                    o.count   = 2'd1;
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                    // eat one trailing space, otherwise lex the byte afresh
                    if (text_byte != BYTE_SPACE) begin
                        o.r1      = idle.res;
                        o.count   = idle.emit ? 2'd2 : 2'd1;
                        mode_next = idle.mode;
                        cont_next = idle.cont;
                        len_next  = idle.bslash ? LEN_W'(1) : '0;
                    end
                end
            end
            MODE_UTF8: begin
                o.count = 2'd1;
                if (text_byte == BYTE_NUL) begin
                    o.r0      = mk_res(KIND_CHAR, BYTE_NUL, 1'b0, 1'b1);
                    o.r1      = idle.res;
                    o.count   = 2'd2;
                    mode_next = MODE_IDLE;
                    cont_next = 2'd0;
                end else begin
                    cont_next = cont_dec;
                    o.r0      = mk_res(KIND_CHAR, text_byte, 1'b1, cont_dec == 2'd0);
                    if (cont_dec == 2'd0) begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            default: begin
                o.r0      = idle.res;
                o.count   = idle.emit ? 2'd1 : 2'd0;
                mode_next = idle.mode;
                cont_next = idle.cont;
                len_next  = idle.bslash ? LEN_W'(1) : '0;
            end
        endcase
        // mark the last result of this item
        if (o.count == 2'd1) begin
            o.r0.last = 1'b1;
        end
        if (o.count == 2'd2) begin
            o.r1.last = 1'b1;
        end
    end

    assign lex_out = o;

    // Advance state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            cont_reg <= 2'd0;
            len_reg  <= '0;
        end else if (en) begin
            mode_reg <= mode_next;
            cont_reg <= cont_next;
            len_reg  <= len_next;
        end
    end

endmodule

### rtl/ttl_queue.sv
// Small result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
// Depends on ttl_pkg.
module ttl_queue
    import ttl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  lex_out_t lex_in,
    output logic     room,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_res
);

    result_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [1:0]        n_push;
    logic              pop;

    assign n_push    = push ? lex_in.count : 2'd0;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_res   = slot_reg[rd_reg];
    // accept an item only with space for two results
    assign room      = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // Store results
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            slot_reg[wr_reg] <= lex_in.r0;
        end
        if (n_push == 2'd2) begin
            slot_reg[wr_reg + QPTR_W'(1)] <= lex_in.r1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + QPTR_W'(n_push);
            rd_reg  <= rd_reg + QPTR_W'(pop);
            cnt_reg <= cnt_reg + QCNT_W'(n_push) - QCNT_W'(pop);
        end
    end

endmodule
